@@ rtl/core/lru_result_cache_top_macros.svh @@
// Assertion macros shared by the cache RTL.
`ifndef LRU_RESULT_CACHE_TOP_MACROS_SVH
`define LRU_RESULT_CACHE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LRC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LRC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LRC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LRC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/lrc_pkg.sv @@
package lrc_pkg;
    localparam int DEFAULT_ENTRIES = 16;
    localparam int CAP_W  = 5;
    localparam int KEY_W  = 64;
    localparam int WORD_W = 64;
    localparam int VAL_W  = 3 * WORD_W;
    localparam int DROP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_OUT
    } t_state;
endpackage

@@ rtl/core/lrc_ram.sv @@
module lrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/lru_result_cache_top.sv @@
// Fully associative LRU cache for 64-bit keys with a three-word value.
// Input channel (s_axis): tuser carries the opcode (lookup or insert), tdata
// the key and the value words. Output channel (m_axis): one item per input
// item, tuser is the hit flag, tdata the value read on a lookup hit and the
// number of entries dropped by an insert.
// The capacity register is written over its own valid/ready channel; the user
// must write it only while the cache is idle, which the block does not enforce.
// Values above the number of entries act as full size. Each item scans the
// key memory one entry per cycle, since the key memory has a single read port.
// A hit ends the scan early; a miss scans all entries. The item then passes
// through the update and output states to the output register; one item is
// worked on at a time, and the next item can be accepted in the cycle after
// the result is loaded into the output register. The result waits in the
// output register while the receiver stalls; the next item is accepted and
// scanned meanwhile, and its result waits until the output register is free.
// Reset clears all valid marks, recency ranks, the entry count and the
// capacity register (to 16); no memory clearing pass is needed.
module lru_result_cache_top #(
    parameter int ENTRIES = lrc_pkg::DEFAULT_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [lrc_pkg::CAP_W-1:0] i_cfg_data,     // capacity
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [255:0]             i_s_axis_tdata,  // lookup_key, value_magnitude,
                                                      // value_angle, value_node
    input  logic                     i_s_axis_tuser,  // opcode
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [199:0]             o_m_axis_tdata,  // out_magnitude, out_angle,
                                                      // out_node, dropped, zero pad
    output logic                     o_m_axis_tuser   // hit
);
    import lrc_pkg::*;
    `include "lru_result_cache_top_macros.svh"

    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int MW    = (CNT_W > CAP_W) ? CNT_W + 1 : CAP_W + 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
    localparam logic [MW-1:0] ENT_M = MW'(ENTRIES);

    t_state r_state, n_state;

    logic [CAP_W-1:0]  r_cap;
    logic              r_op;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [IW-1:0]     r_idx, r_cmp_idx, r_slot;
    logic              r_issue_done, r_cmp_vld, r_hit;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [IW-1:0]     r_age [ENTRIES];
    logic [IW-1:0]     n_age [ENTRIES];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DROP_W-1:0] r_drop, n_drop;
    logic              r_out_valid;
    logic [199:0]      r_out_data;
    logic              r_out_user;

    logic              key_re, key_we, val_re, val_we;
    logic [KEY_W-1:0]  key_rdata;
    logic [VAL_W-1:0]  val_rdata;
    logic [IW-1:0]     wr_slot, free_slot;
    logic              cmp_hit, new_ins, out_load;
    logic [MW-1:0]     cap_eff, cnt_m;
    logic [ENTRIES-1:0] v_kept;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    assign cmp_hit  = r_cmp_vld && r_valid[r_cmp_idx] && (key_rdata == r_key);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);
    assign new_ins  = (r_op == OP_INSERT) && !r_hit && (r_cap != '0);
    assign wr_slot  = r_hit ? r_slot : free_slot;

    lrc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(free_slot),
        .i_wdata(r_key),
        .i_re   (key_re),
        .i_raddr(r_idx),
        .o_rdata(key_rdata)
    );

    lrc_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(wr_slot),
        .i_wdata(r_val),
        .i_re   (val_re),
        .i_raddr(r_slot),
        .o_rdata(val_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cmp_hit || (r_cmp_vld && r_cmp_idx == LAST)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        key_re = 1'b0;
        key_we = 1'b0;
        val_re = 1'b0;
        val_we = 1'b0;
        case (r_state)
            S_SCAN: key_re = !r_issue_done;
            S_UPDATE: begin
                val_re = r_hit && (r_op == OP_LOOKUP);
                val_we = (r_op == OP_INSERT) && (r_hit || new_ins);
                key_we = new_ins;
            end
            default: begin
                key_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        cap_eff = (MW'(r_cap) > ENT_M) ? ENT_M : MW'(r_cap);
        cnt_m   = MW'(r_count);
        n_valid = r_valid;
        n_count = r_count;
        n_drop  = '0;
        v_kept  = r_valid;
        free_slot = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            n_age[i] = r_age[i];
        end
        if (r_hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && r_age[i] < r_age[r_slot]) begin
                    n_age[i] = r_age[i] + 1'b1;
                end
            end
            n_age[r_slot] = '0;
        end else if (r_op == OP_INSERT && r_cap == '0) begin
            n_valid = '0;
            n_count = '0;
            n_drop  = DROP_W'(cnt_m + 1'b1);
            for (int i = 0; i < ENTRIES; i++) begin
                n_age[i] = '0;
            end
        end else if (r_op == OP_INSERT) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && cnt_m >= cap_eff && MW'(r_age[i]) >= cap_eff - 1'b1) begin
                    v_kept[i] = 1'b0;
                end
                n_age[i] = v_kept[i] ? r_age[i] + 1'b1 : '0;
            end
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!v_kept[i]) begin
                    free_slot = IW'(i);
                end
            end
            n_valid = v_kept;
            n_valid[free_slot] = 1'b1;
            n_age[free_slot] = '0;
            if (cnt_m >= cap_eff) begin
                n_count = CNT_W'(cap_eff);
                n_drop  = DROP_W'(cnt_m - cap_eff + 1'b1);
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_issue_done <= 1'b0;
            r_hit       <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op  <= i_s_axis_tuser;
                        r_key <= i_s_axis_tdata[63:0];
                        r_val <= i_s_axis_tdata[255:64];
                        r_idx <= '0;
                        r_issue_done <= 1'b0;
                        r_cmp_vld <= 1'b0;
                        r_hit <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_cmp_idx <= r_idx;
                    if (cmp_hit) begin
                        r_hit  <= 1'b1;
                        r_slot <= r_cmp_idx;
                        r_issue_done <= 1'b1;
                        r_cmp_vld <= 1'b0;
                    end else begin
                        r_cmp_vld <= !r_issue_done;
                        if (!r_issue_done) begin
                            r_idx <= r_idx + 1'b1;
                            r_issue_done <= (r_idx == LAST);
                        end
                    end
                end
                S_UPDATE: begin
                    r_valid <= n_valid;
                    r_count <= n_count;
                    r_drop  <= n_drop;
                    for (int i = 0; i < ENTRIES; i++) begin
                        r_age[i] <= n_age[i];
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_user  <= r_hit;
                        r_out_data  <= {3'b000, r_drop,
                            (r_hit && r_op == OP_LOOKUP) ? val_rdata : {VAL_W{1'b0}}};
                    end
                end
                default: begin
                    r_cmp_vld <= 1'b0;
                end
            endcase
        end
    end

    `LRC_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, 1'b1,
        $countones(r_valid) == int'(r_count))
    `LRC_ASSERT_NXT(a_accept_scans, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, r_state == S_SCAN)
    `LRC_ASSERT_IMP(a_result_from_out, i_clk, i_rst_n,
        $rose(r_out_valid), $past(r_state) == S_OUT)
endmodule

@@ bench/lru_result_cache_top_tb.sv @@
`default_nettype none

typedef struct packed {
    logic        hit;
    logic [63:0] mag;
    logic [63:0] ang;
    logic [63:0] node;
    logic [4:0]  dropped;
} cache_result_t;

class cache_scoreboard;
    logic [63:0]   slot_key[16];
    logic [63:0]   slot_mag[16];
    logic [63:0]   slot_ang[16];
    logic [63:0]   slot_node[16];
    bit            slot_vld[16];
    int            slot_age[16];
    int            fill;
    logic [4:0]    capacity;
    cache_result_t pending_results[$];
    int            errors;

    function new();
        capacity = lrc_pkg::CAP_RESET;
        fill = 0;
        errors = 0;
        foreach (slot_vld[i]) begin
            slot_vld[i] = 0;
            slot_age[i] = 0;
        end
    endfunction

    function void set_capacity(logic [4:0] c);
        capacity = c;
    endfunction

    function void make_recent(int s);
        int a;
        a = slot_age[s];
        for (int i = 0; i < 16; i++) begin
            if (slot_vld[i] && slot_age[i] < a) slot_age[i]++;
        end
        slot_age[s] = 0;
    endfunction

    function void note_item(logic op, logic [63:0] key, logic [63:0] mag,
                            logic [63:0] ang, logic [63:0] node);
        cache_result_t r;
        int s;
        int v;
        int lim;
        int free_slot;
        s = -1;
        for (int i = 0; i < 16; i++) begin
            if (s < 0 && slot_vld[i] && slot_key[i] == key) s = i;
        end
        r = '0;
        r.hit = (s >= 0);
        if (op == lrc_pkg::OP_LOOKUP) begin
            if (s >= 0) begin
                r.mag = slot_mag[s];
                r.ang = slot_ang[s];
                r.node = slot_node[s];
                make_recent(s);
            end
        end else if (s >= 0) begin
            slot_mag[s] = mag;
            slot_ang[s] = ang;
            slot_node[s] = node;
            make_recent(s);
        end else if (capacity == 0) begin
            r.dropped = 5'(fill + 1);
            foreach (slot_vld[i]) begin
                slot_vld[i] = 0;
                slot_age[i] = 0;
            end
            fill = 0;
        end else begin
            lim = (capacity > 16) ? 16 : capacity;
            while (fill >= lim) begin
                v = -1;
                for (int i = 0; i < 16; i++) begin
                    if (slot_vld[i] && (v < 0 || slot_age[i] > slot_age[v])) v = i;
                end
                slot_vld[v] = 0;
                slot_age[v] = 0;
                fill--;
                r.dropped++;
            end
            for (int i = 0; i < 16; i++) begin
                if (slot_vld[i]) slot_age[i]++;
            end
            free_slot = -1;
            for (int i = 0; i < 16; i++) begin
                if (free_slot < 0 && !slot_vld[i]) free_slot = i;
            end
            slot_vld[free_slot] = 1;
            slot_key[free_slot] = key;
            slot_mag[free_slot] = mag;
            slot_ang[free_slot] = ang;
            slot_node[free_slot] = node;
            slot_age[free_slot] = 0;
            fill++;
        end
        pending_results.push_back(r);
    endfunction

    function void check_result(cache_result_t got);
        cache_result_t want;
        if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result item %h", got);
            return;
        end
        want = pending_results.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) begin
                $display("Mismatch: expected hit=%0d mag=%h ang=%h node=%h dropped=%0d",
                         want.hit, want.mag, want.ang, want.node, want.dropped);
                $display("          actual   hit=%0d mag=%h ang=%h node=%h dropped=%0d",
                         got.hit, got.mag, got.ang, got.node, got.dropped);
            end
        end
    endfunction
endclass

module lru_result_cache_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lrc_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [4:0]   i_cfg_data = '0;
    logic         i_s_axis_tvalid = 0;
    logic         o_s_axis_tready;
    logic [255:0] i_s_axis_tdata = '0;
    logic         i_s_axis_tuser = 0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1;
    logic [199:0] o_m_axis_tdata;
    logic         o_m_axis_tuser;

    cache_scoreboard sb = new();
    bit          sender_gaps = 1;
    bit          receiver_gaps = 1;
    bit          long_hold_req = 0;
    int          quiet_cycles = 0;
    logic [63:0] key_pool[24];

    lru_result_cache_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_item(i_s_axis_tuser, i_s_axis_tdata[63:0], i_s_axis_tdata[127:64],
                             i_s_axis_tdata[191:128], i_s_axis_tdata[255:192]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result({o_m_axis_tuser, o_m_axis_tdata[63:0],
                                 o_m_axis_tdata[127:64], o_m_axis_tdata[191:128],
                                 o_m_axis_tdata[196:192]});
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 0;
            i_m_axis_tready <= 0;
            repeat (300) @(negedge i_clk);
            i_m_axis_tready <= 1;
        end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            i_m_axis_tready <= 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            i_m_axis_tready <= 1;
        end else begin
            i_m_axis_tready <= 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(logic op, logic [63:0] key, logic [63:0] mag,
                             logic [63:0] ang, logic [63:0] node);
        @(negedge i_clk);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= {node, ang, mag, key};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_random(logic op, logic [63:0] key);
        send_item(op, key, rand64(), rand64(), rand64());
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [4:0] c);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_capacity(c);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic random_phase(int n);
        logic [63:0] k;
        repeat (n) begin
            k = ($urandom_range(0, 4) == 0) ? rand64() : key_pool[$urandom_range(0, 23)];
            send_random(1'($urandom_range(0, 1)), k);
        end
    endtask

    initial begin
        logic [4:0] caps[8];
        caps = '{5'd0, 5'd1, 5'd31, 5'd5, 5'd17, 5'd3, 5'd16, 5'd2};
        foreach (key_pool[i]) key_pool[i] = rand64();
        key_pool[0] = 64'h8000_0000_0000_0000;
        key_pool[1] = 64'h7FFF_FFFF_FFFF_FFFF;
        key_pool[2] = '0;
        key_pool[3] = '1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        send_random(OP_LOOKUP, key_pool[0]);
        send_item(OP_INSERT, key_pool[1], '1, '1, 64'h8000_0000_0000_0000);
        send_item(OP_INSERT, key_pool[0], '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_random(OP_LOOKUP, key_pool[1]);
        send_random(OP_LOOKUP, key_pool[0]);
        send_random(OP_INSERT, key_pool[1]);
        send_random(OP_LOOKUP, key_pool[1]);
        send_random(OP_LOOKUP, key_pool[2]);
        for (int i = 2; i < 18; i++) send_random(OP_INSERT, key_pool[i]);
        send_random(OP_LOOKUP, key_pool[0]);
        settle();

        write_capacity(5'd4);
        settle();
        for (int p = 0; p < 8; p++) begin
            write_capacity(caps[p]);
            if (caps[p] == 5'd31) long_hold_req = 1;
            if (p == 7) begin
                sender_gaps = 0;
                receiver_gaps = 0;
            end
            random_phase(65);
            settle();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire

@@ lru_result_cache_top.f @@
+incdir+rtl/core
rtl/core/lrc_pkg.sv
rtl/core/lrc_ram.sv
rtl/core/lru_result_cache_top.sv
bench/lru_result_cache_top_tb.sv
